// ===== rtl/mmrm_pkg.sv =====
// ----------------------------------------------------------------------------
// mmrm_pkg
// Shared types and codes for the row-streamed matrix multiply-accumulate unit.
// ----------------------------------------------------------------------------
package mmrm_pkg;

    localparam int ACC_BITS   = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_RESET  = 16;
    localparam int COL_OUT_W  = 4;
    localparam int B_ADDR_W   = 4;

    // operation codes
    localparam logic OP_B_WRITE = 1'b0;
    localparam logic OP_A_ELEM  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_N_COLS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_K_DEPTH = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN0,
        S_DRAIN1
    } mmrm_state_t;

    // per-column control that travels down the mac pipeline
    typedef struct packed {
        logic vld;
        logic first;    // first element of the row: accumulator starts from zero
        logic last;     // last element of the row: sum goes out, not back
        logic end_col;  // final column of the row
    } mmrm_ctl_t;

endpackage

// ===== rtl/matrix_multiply_row_mac_unit.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_row_mac_unit
// Row-streamed matrix product in i-k-j order with one shared multiply-add.
// ----------------------------------------------------------------------------
//  channel   signals                                       handshake
//  -------   --------------------------------------------  -------------------------
//  item in   start, operation, value, b_row, b_col         start & !busy
//  result    strobe, result_value, col_index, row_last     strobe, one cycle each
//  config    cfg_valid, cfg_index, cfg_data, cfg_ready     cfg_valid & cfg_ready
//
//  a B write never raises busy; an A item holds busy while it issues one column
//  per cycle through the single multiply-add and then drains, so a new item is
//  taken only once the last is through. a row's results follow its last A item
//  through the s1, s2 and result registers, one column per cycle, and cannot be
//  stalled. reset clears control and sets both sizes to 16, clamped to the
//  maximums; the B table is undefined until written and needs no clearing pass.
// ----------------------------------------------------------------------------
module matrix_multiply_row_mac_unit #(
    parameter int MAX_COLS  = 16,
    parameter int MAX_INNER = 16,
    parameter int ELEM_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    operation,
    input  logic signed [ELEM_BITS-1:0]             value,
    input  logic [mmrm_pkg::B_ADDR_W-1:0]           b_row,
    input  logic [mmrm_pkg::B_ADDR_W-1:0]           b_col,
    output logic                                    strobe,
    output logic signed [mmrm_pkg::ACC_BITS-1:0]    result_value,
    output logic [mmrm_pkg::COL_OUT_W-1:0]          col_index,
    output logic                                    row_last,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [mmrm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [mmrm_pkg::CFG_DATA_W-1:0]         cfg_data
);

    import mmrm_pkg::*;

    localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int PW     = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int BDEPTH = MAX_INNER * MAX_COLS;
    localparam int BW     = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int N_RST  = (CFG_RESET > MAX_COLS) ? MAX_COLS : CFG_RESET;
    localparam int K_RST  = (CFG_RESET > MAX_INNER) ? MAX_INNER : CFG_RESET;

    logic [CW-1:0]        n_last_reg, n_last_next;
    logic [PW-1:0]        k_last_reg, k_last_next;
    logic                 cfg_take;
    logic                 row_clear;
    logic                 take;
    logic                 a_take;
    logic                 b_we;
    logic [BW-1:0]        b_waddr;
    logic [BW-1:0]        b_raddr;
    logic [ELEM_BITS-1:0] b_rdata;
    mmrm_ctl_t            issue;
    logic [CW-1:0]        issue_col;
    logic [PW-1:0]        issue_pos;

    assign cfg_ready = !busy;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign row_clear = cfg_take && (cfg_index == REG_N_COLS || cfg_index == REG_K_DEPTH);

    // registers are kept as count minus one, clamped to 1..max
    always_comb
    begin
        n_last_next = n_last_reg;
        k_last_next = k_last_reg;
        if (cfg_take)
        begin
            unique case (cfg_index)
                REG_N_COLS:
                begin
                    if (cfg_data == '0)
                        n_last_next = '0;
                    else if (32'(cfg_data) > MAX_COLS)
                        n_last_next = CW'(MAX_COLS - 1);
                    else
                        n_last_next = CW'(cfg_data - 1'b1);
                end
                REG_K_DEPTH:
                begin
                    if (cfg_data == '0)
                        k_last_next = '0;
                    else if (32'(cfg_data) > MAX_INNER)
                        k_last_next = PW'(MAX_INNER - 1);
                    else
                        k_last_next = PW'(cfg_data - 1'b1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_last_reg <= CW'(N_RST - 1);
            k_last_reg <= PW'(K_RST - 1);
        end
        else
        begin
            n_last_reg <= n_last_next;
            k_last_reg <= k_last_next;
        end
    end

    assign take    = start && !busy;
    assign a_take  = take && (operation == OP_A_ELEM);
    assign b_we    = take && (operation == OP_B_WRITE)
                     && (32'(b_row) < MAX_INNER) && (32'(b_col) < MAX_COLS);
    assign b_waddr = BW'(32'(b_row) * MAX_COLS + 32'(b_col));
    assign b_raddr = BW'(32'(issue_pos) * MAX_COLS + 32'(issue_col));

    mmrm_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (BDEPTH)
    ) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    mmrm_seq #(
        .MAX_COLS  (MAX_COLS),
        .MAX_INNER (MAX_INNER)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .a_take    (a_take),
        .row_clear (row_clear),
        .n_last    (n_last_reg),
        .k_last    (k_last_reg),
        .busy      (busy),
        .issue     (issue),
        .issue_col (issue_col),
        .issue_pos (issue_pos)
    );

    mmrm_mac #(
        .MAX_COLS  (MAX_COLS),
        .ELEM_BITS (ELEM_BITS)
    ) u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .a_load       (a_take),
        .a_value      (value),
        .issue        (issue),
        .issue_col    (issue_col),
        .b_rdata      (b_rdata),
        .strobe       (strobe),
        .result_value (result_value),
        .col_index    (col_index),
        .row_last     (row_last)
    );

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result without an item in flight");

    a_row_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !row_last)
            |=> (strobe && col_index == COL_OUT_W'($past(col_index) + 1'b1)))
        else $error("result row broken or columns out of order");

    a_row_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && row_last) |=> !strobe)
        else $error("result after the last column of a row");

endmodule

// ===== rtl/mmrm_ram.sv =====
// ----------------------------------------------------------------------------
// mmrm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mmrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/mmrm_seq.sv =====
// ----------------------------------------------------------------------------
// mmrm_seq
// Sequencer: walks the columns for one A item and tracks the inner position.
// ----------------------------------------------------------------------------
module mmrm_seq #(
    parameter int MAX_COLS  = 16,
    parameter int MAX_INNER = 16
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             a_take,
    input  logic                                             row_clear,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0]   n_last,
    input  logic [((MAX_INNER > 1) ? $clog2(MAX_INNER) : 1)-1:0] k_last,
    output logic                                             busy,
    output mmrm_pkg::mmrm_ctl_t                              issue,
    output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0]   issue_col,
    output logic [((MAX_INNER > 1) ? $clog2(MAX_INNER) : 1)-1:0] issue_pos
);

    import mmrm_pkg::*;

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int PW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

    mmrm_state_t   state_reg, state_next;
    logic [CW-1:0] col_reg, col_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic          first_reg, first_next;
    logic          last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            col_reg   <= '0;
            pos_reg   <= '0;
            first_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            pos_reg   <= pos_next;
            first_reg <= first_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        pos_next   = pos_reg;
        first_next = first_reg;
        last_next  = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (row_clear)
                begin
                    pos_next = '0;
                end
                else if (a_take)
                begin
                    state_next = S_ISSUE;
                    col_next   = '0;
                    first_next = (pos_reg == '0);
                    last_next  = (pos_reg == k_last);
                end
            end
            S_ISSUE:
            begin
                if (col_reg == n_last)
                begin
                    state_next = S_DRAIN0;
                    pos_next   = last_reg ? '0 : PW'(pos_reg + 1'b1);
                end
                else
                begin
                    col_next = CW'(col_reg + 1'b1);
                end
            end
            // the drain states let the last column's sum land in the accumulator
            S_DRAIN0:
            begin
                state_next = S_DRAIN1;
            end
            S_DRAIN1:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != S_IDLE);
    assign issue.vld     = (state_reg == S_ISSUE);
    assign issue.first   = first_reg;
    assign issue.last    = last_reg;
    assign issue.end_col = (col_reg == n_last);
    assign issue_col     = col_reg;
    // position of the item in flight, advanced only once its last column has issued
    assign issue_pos     = pos_reg;

    a_issue_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ISSUE && col_reg == n_last) |=> state_reg == S_DRAIN0)
        else $error("issue did not stop at the last column");

    a_issue_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ISSUE && col_reg != n_last)
            |=> (state_reg == S_ISSUE && col_reg == CW'($past(col_reg) + 1'b1)))
        else $error("column walk skipped or stalled");

    a_row_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ISSUE && col_reg == n_last && last_reg) |=> pos_reg == '0)
        else $error("inner position did not wrap at the end of a row");

endmodule

// ===== rtl/mmrm_mac.sv =====
// ----------------------------------------------------------------------------
// mmrm_mac
// Shared multiply-accumulate datapath: one column per cycle through
// multiply, accumulate and result stages, accumulators held in a RAM.
// ----------------------------------------------------------------------------
module mmrm_mac #(
    parameter int MAX_COLS  = 16,
    parameter int ELEM_BITS = 16
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           a_load,
    input  logic signed [ELEM_BITS-1:0]                    a_value,
    input  mmrm_pkg::mmrm_ctl_t                            issue,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] issue_col,
    input  logic [ELEM_BITS-1:0]                           b_rdata,
    output logic                                           strobe,
    output logic signed [mmrm_pkg::ACC_BITS-1:0]           result_value,
    output logic [mmrm_pkg::COL_OUT_W-1:0]                 col_index,
    output logic                                           row_last
);

    import mmrm_pkg::*;

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int PW = 2 * ELEM_BITS;

    logic signed [ELEM_BITS-1:0] a_reg;
    mmrm_ctl_t                   s1_reg, s2_reg;
    logic [CW-1:0]               s1_col_reg, s2_col_reg;
    logic signed [PW-1:0]        prod_reg, prod_next;
    logic [ACC_BITS-1:0]         acc_rdata;
    logic [ACC_BITS-1:0]         sum;
    logic                        acc_we;
    logic                        strobe_reg;
    logic [ACC_BITS-1:0]         result_reg;
    logic [COL_OUT_W-1:0]        col_out_reg;
    logic                        row_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg     <= '0;
            s2_reg     <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            s1_reg     <= issue;
            s2_reg     <= s1_reg;
            strobe_reg <= s2_reg.vld && s2_reg.last;
        end
    end

    assign prod_next = a_reg * $signed(b_rdata);

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_reg <= a_value;
        end
        s1_col_reg   <= issue_col;
        s2_col_reg   <= s1_col_reg;
        prod_reg     <= prod_next;
        result_reg   <= sum;
        col_out_reg  <= COL_OUT_W'(s2_col_reg);
        row_last_reg <= s2_reg.end_col;
    end

    // first element of a row overwrites, so the accumulators never need clearing
    assign sum    = (s2_reg.first ? '0 : acc_rdata) + ACC_BITS'(prod_reg);
    assign acc_we = s2_reg.vld && !s2_reg.last;

    mmrm_ram #(
        .WIDTH (ACC_BITS),
        .DEPTH (MAX_COLS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (s2_col_reg),
        .wdata (sum),
        .raddr (s1_col_reg),
        .rdata (acc_rdata)
    );

    assign strobe       = strobe_reg;
    assign result_value = result_reg;
    assign col_index    = col_out_reg;
    assign row_last     = row_last_reg;

endmodule

// ===== verif/matrix_multiply_row_mac_unit_test.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_row_mac_unit_test
// Self-checking bench for the row-streamed matrix multiply-accumulate unit.
// B elements are loaded, then A rows are streamed through several size
// settings. A scoreboard class keeps its own copy of the B table, the column
// sums and the sizes, and checks every result word in order of arrival.
// ----------------------------------------------------------------------------
module matrix_multiply_row_mac_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mmrm_pkg::*;

    localparam int MAX_COLS      = 16;
    localparam int MAX_INNER     = 16;
    localparam int CLK_PERIOD    = 12;
    localparam int SETTLE_CYCLES = 24;
    localparam int ITEM_TARGET   = 380;
    localparam int QUIET_FROM    = 320;

    // indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic signed [ACC_BITS-1:0] sum;
        logic [COL_OUT_W-1:0]       col;
        logic                       last;
    } col_result_t;

    class row_product_board;
        logic signed [15:0]    b_store [MAX_INNER][MAX_COLS];
        bit                    filled [MAX_INNER][MAX_COLS];
        logic [ACC_BITS-1:0]   col_sums [MAX_COLS];
        int unsigned           inner_count;
        logic [CFG_DATA_W-1:0] n_cols_reg;
        logic [CFG_DATA_W-1:0] k_depth_reg;
        col_result_t           pending [$];
        int unsigned           errors;
        int unsigned           checked;
        int unsigned           rows_done;

        function new();
            n_cols_reg  = CFG_RESET;
            k_depth_reg = CFG_RESET;
            foreach (filled[r, c])
                filled[r][c] = 1'b0;
            clear_row();
        endfunction

        function void clear_row();
            foreach (col_sums[j])
                col_sums[j] = '0;
            inner_count = 0;
        endfunction

        static function int unsigned clamp_size(logic [CFG_DATA_W-1:0] v, int unsigned top);
            if (v == 0)
                return 1;
            if (v > top)
                return top;
            return v;
        endfunction

        function int unsigned active_cols();
            return clamp_size(n_cols_reg, MAX_COLS);
        endfunction

        function int unsigned active_depth();
            return clamp_size(k_depth_reg, MAX_INNER);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_N_COLS)
                n_cols_reg = data;
            else if (idx == REG_K_DEPTH)
                k_depth_reg = data;
            else
                return;
            clear_row();
        endfunction

        function void note_item(logic op, logic signed [15:0] elem,
                                logic [B_ADDR_W-1:0] row, logic [B_ADDR_W-1:0] col);
            int unsigned        n;
            int unsigned        k;
            logic signed [31:0] prod;
            col_result_t        r;
            n = active_cols();
            k = active_depth();
            if (op == OP_B_WRITE)
            begin
                b_store[row][col] = elem;
                filled[row][col]  = 1'b1;
                return;
            end
            if (inner_count >= k)
                inner_count = 0;
            for (int j = 0; j < n; j++)
            begin
                prod = elem * b_store[inner_count][j];
                col_sums[j] = col_sums[j] + {{(ACC_BITS-32){prod[31]}}, prod};
            end
            inner_count++;
            if (inner_count < k)
                return;
            for (int j = 0; j < n; j++)
            begin
                r.sum  = col_sums[j];
                r.col  = COL_OUT_W'(j);
                r.last = (j == n - 1);
                pending.push_back(r);
            end
            rows_done++;
            clear_row();
        endfunction

        function void check_result(logic signed [ACC_BITS-1:0] sum,
                                   logic [COL_OUT_W-1:0] col, logic last);
            col_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: result with none expected: expected none, got value %0d col %0d last %0b",
                         $time, sum, col, last);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (sum !== want.sum)
            begin
                $display("%0t: result_value mismatch col %0d: expected %0d, got %0d",
                         $time, want.col, want.sum, sum);
                errors++;
            end
            if (col !== want.col)
            begin
                $display("%0t: col_index mismatch: expected %0d, got %0d", $time, want.col, col);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t: row_last mismatch col %0d: expected %0b, got %0b",
                         $time, want.col, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic                        operation = OP_B_WRITE;
    logic signed [15:0]          value = '0;
    logic [B_ADDR_W-1:0]         b_row = '0;
    logic [B_ADDR_W-1:0]         b_col = '0;
    logic                        strobe;
    logic signed [ACC_BITS-1:0]  result_value;
    logic [COL_OUT_W-1:0]        col_index;
    logic                        row_last;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;

    row_product_board board = new();
    int unsigned      items_sent = 0;
    int unsigned      cfg_writes = 0;
    int unsigned      gap_odds = 0;

    matrix_multiply_row_mac_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .value        (value),
        .b_row        (b_row),
        .b_col        (b_col),
        .strobe       (strobe),
        .result_value (result_value),
        .col_index    (col_index),
        .row_last     (row_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            board.check_result(result_value, col_index, row_last);
    end

    // a gap_odds of zero means back-to-back items
    task automatic send_item(input logic op, input logic signed [15:0] elem,
                             input logic [B_ADDR_W-1:0] row, input logic [B_ADDR_W-1:0] col);
        start     <= 1'b1;
        operation <= op;
        value     <= elem;
        b_row     <= row;
        b_col     <= col;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_item(op, elem, row, col);
        items_sent++;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic send_a(input logic signed [15:0] elem);
        send_item(OP_A_ELEM, elem, B_ADDR_W'($urandom), B_ADDR_W'($urandom));
    endtask

    // hold off until all results are in, then give a trailing partial row time to finish
    task automatic wait_drained();
        start <= 1'b0;
        while (board.pending.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(idx, data);
        cfg_writes++;
        if (!more)
            cfg_valid <= 1'b0;
    endtask

    // stray writes go last so a decode fault would show in the next rows
    task automatic program_regs(input logic [CFG_DATA_W-1:0] n_data,
                                input logic [CFG_DATA_W-1:0] k_data, input bit stray);
        wait_drained();
        write_reg(REG_N_COLS, n_data, 1'b1);
        write_reg(REG_K_DEPTH, k_data, stray);
        if (stray)
        begin
            write_reg(REG_SPARE_2, CFG_DATA_W'($urandom), 1'b1);
            write_reg(REG_SPARE_3, CFG_DATA_W'($urandom), 1'b0);
        end
    endtask

    // every B entry an A row will read must hold a written value
    task automatic fill_b_table();
        for (int r = 0; r < board.active_depth(); r++)
            for (int c = 0; c < board.active_cols(); c++)
                if (!board.filled[r][c] || $urandom_range(0, 5) == 0)
                    send_item(OP_B_WRITE, 16'($urandom), B_ADDR_W'(r), B_ADDR_W'(c));
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll < 13)
            return CFG_DATA_W'($urandom_range(1, 4));
        if (roll < 17)
            return CFG_DATA_W'($urandom_range(5, 16));
        // out of range settings: zero and above the maximum
        if ($urandom_range(0, 1) == 0)
            return '0;
        return CFG_DATA_W'($urandom_range(17, 31));
    endfunction

    initial
    begin
        int unsigned           phase;
        int unsigned           rows;
        int unsigned           k;
        logic [CFG_DATA_W-1:0] n_data;
        logic [CFG_DATA_W-1:0] k_data;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: one by one, with both sizes given as zero
        gap_odds = 3;
        program_regs('0, '0, 1'b0);
        send_item(OP_B_WRITE, 16'sh7FFF, '0, '0);
        send_a(16'sh8000);
        send_a(16'sh7FFF);
        send_a(16'sh0000);
        send_item(OP_B_WRITE, 16'sh8000, '0, '0);
        send_a(16'sh8000);
        send_a(16'sh0001);
        // writes to unused indexes must leave one by one in place
        program_regs('0, '0, 1'b1);
        send_a(16'sh0100);

        // two by two: a dropped partial row, then a B write in the middle of a row
        program_regs(5'd2, 5'd2, 1'b0);
        send_item(OP_B_WRITE, 16'shFFFF, 4'd0, 4'd1);
        send_item(OP_B_WRITE, 16'sh0100, 4'd1, 4'd0);
        send_item(OP_B_WRITE, 16'sh7F80, 4'd1, 4'd1);
        send_a(16'sh0180);
        program_regs(5'd2, 5'd2, 1'b0);
        send_a(16'sh0200);
        send_item(OP_B_WRITE, 16'sh8000, 4'd1, 4'd1);
        send_a(16'sh8000);

        // random phases; the first two take the widest and the deepest setting
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase == 0)
            begin
                n_data = 5'd31;
                k_data = 5'd1;
            end
            else if (phase == 1)
            begin
                n_data = 5'd1;
                k_data = 5'd20;
            end
            else
            begin
                n_data = pick_size();
                k_data = pick_size();
                if (row_product_board::clamp_size(n_data, MAX_COLS) *
                    row_product_board::clamp_size(k_data, MAX_INNER) > 48)
                    k_data = CFG_DATA_W'($urandom_range(1, 3));
            end
            program_regs(n_data, k_data, $urandom_range(0, 7) == 0);
            if (items_sent >= QUIET_FROM || $urandom_range(0, 2) == 0)
                gap_odds = 0;
            else
                gap_odds = $urandom_range(2, 6);
            fill_b_table();
            k = board.active_depth();
            rows = $urandom_range(1, 4);
            repeat (rows)
            begin
                for (int e = 0; e < k; e++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(OP_B_WRITE, 16'($urandom), B_ADDR_W'($urandom),
                                  B_ADDR_W'($urandom));
                    send_a(16'($urandom));
                end
            end
            // broken row, dropped by the next register write
            if (k > 1 && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, k - 1)) send_a(16'($urandom));
            phase++;
        end

        wait_drained();
        $display("covered %0d items in %0d random phases with %0d register writes",
                 items_sent, phase, cfg_writes);
        $display("%0d rows completed, %0d result words checked", board.rows_done, board.checked);
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * 400000);
        $display("timeout at %0t with %0d results outstanding", $time, board.pending.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mmrm_pkg.sv
rtl/mmrm_ram.sv
rtl/mmrm_seq.sv
rtl/mmrm_mac.sv
rtl/matrix_multiply_row_mac_unit.sv
verif/matrix_multiply_row_mac_unit_test.sv
